// ===== hdl/ctbd_pkg.sv =====
package ctbd_pkg;

   // field widths
   localparam int RAW_W = 14;
   localparam int RD_W  = 14;
   localparam int PCT_W = 7;

   // defaults for the top-level parameters
   localparam int DEF_SAMPLES_PER_READING  = 10;
   localparam int DEF_CALIBRATION_READINGS = 50;
   localparam int DEF_MAX_RAW              = 10000;

   localparam int PCT_FULL  = 100;
   localparam int PCT_RESET = 20;

   // stream packing
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 48;
   localparam int RSP_READING_LSB = 0;
   localparam int RSP_STATUS_LSB  = 14;
   localparam int RSP_STATUS_W    = 3;
   localparam int RSP_DRIFT_BIT   = 17;
   localparam int RSP_BASE_LSB    = 18;
   localparam int RSP_THR_LSB     = 32;

   typedef enum logic [RSP_STATUS_W-1:0] {
      STATUS_CALIBRATING = 3'd0,
      STATUS_NO_TOUCH    = 3'd1,
      STATUS_BEGAN       = 3'd2,
      STATUS_TOUCHING    = 3'd3,
      STATUS_RELEASED    = 3'd4
   } status_type;

   // per-reading side band carried down the pipeline
   typedef struct packed {
      logic [RD_W-1:0] reading;
      logic [RD_W-1:0] base;
      logic            calibrating;
      logic            done;
   } side_type;

endpackage

// ===== hdl/cap_touch_baseline_detector.sv =====
// A raw count that completes a reading shows its result on rsp after nine register
// stages: input, sample accumulator, reading divide, calibration accumulator, baseline
// divide, percent multiply, percent divide, threshold, result. Throughput: one raw count
// per cycle unless a stalled rsp result fills the pipeline; every SAMPLES_PER_READING-th
// count yields one result. Synchronous active-high reset clears the accumulators, the
// baseline, the threshold and the touch state, and sets threshold_percent to 20.
module cap_touch_baseline_detector #(
   parameter int SAMPLES_PER_READING  = ctbd_pkg::DEF_SAMPLES_PER_READING,
   parameter int CALIBRATION_READINGS = ctbd_pkg::DEF_CALIBRATION_READINGS,
   parameter int MAX_RAW              = ctbd_pkg::DEF_MAX_RAW
) (
   input  logic                            clock,
   input  logic                            reset,
   // raw count in
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ctbd_pkg::REQ_DATA_W-1:0] req_tdata,   // [13:0] raw_count
   // results out
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ctbd_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [13:0] reading, [16:14] status,
                                                        // [17] drift, [31:18] baseline,
                                                        // [45:32] threshold
   // threshold_percent write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ctbd_pkg::PCT_W-1:0]      csr_data
);
   import ctbd_pkg::*;

   // a count above this never changes the result; the field itself caps at 14 bits
   localparam int RAW_MAX_W = (1 << RAW_W) - 1;
   localparam int RAW_CAP   = (MAX_RAW < RAW_MAX_W) ? MAX_RAW : RAW_MAX_W;
   localparam int SUM_W     = $clog2(SAMPLES_PER_READING * RAW_CAP + 1);
   localparam int CSUM_W    = $clog2(CALIBRATION_READINGS * RAW_CAP + 1);
   localparam int SIDX_W    = $clog2(SAMPLES_PER_READING + 1);
   localparam int CIDX_W    = $clog2(CALIBRATION_READINGS + 1);
   localparam int PROD_W    = RD_W + PCT_W;
   localparam int NSTG      = 9;

   // ---------------------------------------------------------------- control
   // Each stage advances when it is empty or the next one advances, so bubbles
   // (counts that complete no reading) collapse and the input keeps flowing while
   // a result waits on rsp.
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] en;

   logic            sidx_last;

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || rsp_tready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_comb begin
      vld_in[0] = req_tvalid;
      vld_in[1] = vld_ff[0] && sidx_last;   // only the last count of a group moves on
      for (int k = 2; k < NSTG; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_tready = en[0];

   // ---------------------------------------------------------------- config
   logic [PCT_W-1:0] pct_ff;
   logic [PCT_W-1:0] pct_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff <= PCT_W'(PCT_RESET);
      end else if (csr_valid) begin
         pct_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   // above 100 percent the threshold would go negative
   assign pct_sat   = (pct_ff > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct_ff;

   // ---------------------------------------------------------------- stage 0: input
   logic [RAW_W-1:0] raw_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         raw_ff <= req_tdata[RAW_W-1:0];
      end
   end

   // ---------------------------------------------------------------- stage 1: sample sum
   logic [SUM_W-1:0]  sample_sum_ff;
   logic [SUM_W-1:0]  sample_sum_in;
   logic [SIDX_W-1:0] sample_index_ff;
   logic [RAW_W-1:0]  raw_sat;
   logic [SUM_W-1:0]  sum1_ff;

   assign raw_sat       = (raw_ff > RAW_W'(RAW_CAP)) ? RAW_W'(RAW_CAP) : raw_ff;
   assign sample_sum_in = sample_sum_ff + SUM_W'(raw_sat);
   assign sidx_last     = (sample_index_ff == SIDX_W'(SAMPLES_PER_READING - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_sum_ff   <= '0;
         sample_index_ff <= '0;
      end else if (vld_ff[0] && en[1]) begin
         if (sidx_last) begin
            sample_sum_ff   <= '0;
            sample_index_ff <= '0;
         end else begin
            sample_sum_ff   <= sample_sum_in;
            sample_index_ff <= sample_index_ff + SIDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sum1_ff <= sample_sum_in;
      end
   end

   // ---------------------------------------------------------------- stage 2: reading
   logic [RD_W-1:0] reading2;

   ctbd_const_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR    (SAMPLES_PER_READING),
      .QUOTIENT_W (RD_W)
   ) u_reading_div (
      .clock    (clock),
      .enable   (en[2]),
      .dividend (sum1_ff),
      .quotient (reading2)
   );

   // ---------------------------------------------------------------- stage 3: calibration sum
   // This stage keeps its own calibrated flag; the baseline itself lands in the
   // result stage, carried there by the reading that completes calibration.
   logic [CSUM_W-1:0] calib_sum_ff;
   logic [CSUM_W-1:0] calib_sum_in;
   logic [CIDX_W-1:0] calib_index_ff;
   logic              calibrated_ff;
   logic              cidx_last;
   logic [CSUM_W-1:0] csum3_ff;
   side_type          side3_ff;
   side_type          side3_in;

   assign calib_sum_in = calib_sum_ff + CSUM_W'(reading2);
   assign cidx_last    = (calib_index_ff == CIDX_W'(CALIBRATION_READINGS - 1));

   always_comb begin
      side3_in.reading     = reading2;
      side3_in.base        = '0;
      side3_in.calibrating = !calibrated_ff;
      side3_in.done        = !calibrated_ff && cidx_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_sum_ff   <= '0;
         calib_index_ff <= '0;
         calibrated_ff  <= 1'b0;
      end else if (vld_ff[2] && en[3] && !calibrated_ff) begin
         if (cidx_last) begin
            calib_sum_ff   <= '0;
            calib_index_ff <= '0;
            calibrated_ff  <= 1'b1;
         end else begin
            calib_sum_ff   <= calib_sum_in;
            calib_index_ff <= calib_index_ff + CIDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         csum3_ff <= calib_sum_in;
         side3_ff <= side3_in;
      end
   end

   // ---------------------------------------------------------------- stage 4: baseline
   logic [RD_W-1:0] base4;
   side_type        side4_ff;

   ctbd_const_div #(
      .DIVIDEND_W (CSUM_W),
      .DIVISOR    (CALIBRATION_READINGS),
      .QUOTIENT_W (RD_W)
   ) u_baseline_div (
      .clock    (clock),
      .enable   (en[4]),
      .dividend (csum3_ff),
      .quotient (base4)
   );

   always_ff @(posedge clock) begin
      if (en[4]) begin
         side4_ff <= side3_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5: baseline * percent
   logic [PROD_W-1:0] prod5_ff;
   side_type          side5_ff;
   side_type          side5_in;

   always_comb begin
      side5_in      = side4_ff;
      side5_in.base = base4;
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         prod5_ff <= PROD_W'(base4) * PROD_W'(pct_sat);
         side5_ff <= side5_in;
      end
   end

   // ---------------------------------------------------------------- stage 6: / 100
   logic [RD_W-1:0] pctq6;
   side_type        side6_ff;

   ctbd_const_div #(
      .DIVIDEND_W (PROD_W),
      .DIVISOR    (PCT_FULL),
      .QUOTIENT_W (RD_W)
   ) u_percent_div (
      .clock    (clock),
      .enable   (en[6]),
      .dividend (prod5_ff),
      .quotient (pctq6)
   );

   always_ff @(posedge clock) begin
      if (en[6]) begin
         side6_ff <= side5_ff;
      end
   end

   // ---------------------------------------------------------------- stage 7: threshold
   logic [RD_W-1:0] thr7_ff;
   side_type        side7_ff;

   always_ff @(posedge clock) begin
      if (en[7]) begin
         thr7_ff  <= side6_ff.base - pctq6;   // quotient never exceeds the baseline
         side7_ff <= side6_ff;
      end
   end

   // ---------------------------------------------------------------- stage 8: classify, result
   logic [RD_W-1:0] baseline_reg_ff;
   logic [RD_W-1:0] threshold_reg_ff;
   logic            last_touch_ff;
   logic            touched;
   logic            drift_in;
   status_type      status_in;
   logic [RD_W-1:0] base_out_in;
   logic [RD_W-1:0] thr_out_in;

   logic [RD_W-1:0] rsp_reading_ff;
   status_type      rsp_status_ff;
   logic            rsp_drift_ff;
   logic [RD_W-1:0] rsp_base_ff;
   logic [RD_W-1:0] rsp_thr_ff;

   assign touched = side7_ff.reading < threshold_reg_ff;

   always_comb begin
      status_in   = STATUS_CALIBRATING;
      drift_in    = 1'b0;
      base_out_in = baseline_reg_ff;
      thr_out_in  = threshold_reg_ff;
      if (side7_ff.calibrating) begin
         // the completing reading already reports the new baseline and threshold
         if (side7_ff.done) begin
            base_out_in = side7_ff.base;
            thr_out_in  = thr7_ff;
         end
      end else begin
         if (touched && !last_touch_ff) begin
            status_in = STATUS_BEGAN;
         end else if (!touched && last_touch_ff) begin
            status_in = STATUS_RELEASED;
         end else if (touched) begin
            status_in = STATUS_TOUCHING;
         end else begin
            status_in = STATUS_NO_TOUCH;
         end
         drift_in = (side7_ff.reading < (baseline_reg_ff >> 1))
                 || ({1'b0, side7_ff.reading} > {baseline_reg_ff, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_reg_ff  <= '0;
         threshold_reg_ff <= '0;
         last_touch_ff    <= 1'b0;
      end else if (vld_ff[7] && en[8]) begin
         if (side7_ff.calibrating) begin
            if (side7_ff.done) begin
               baseline_reg_ff  <= side7_ff.base;
               threshold_reg_ff <= thr7_ff;
            end
         end else begin
            last_touch_ff <= touched;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         rsp_reading_ff <= side7_ff.reading;
         rsp_status_ff  <= status_in;
         rsp_drift_ff   <= drift_in;
         rsp_base_ff    <= base_out_in;
         rsp_thr_ff     <= thr_out_in;
      end
   end

   assign rsp_tvalid = vld_ff[NSTG-1];
   assign rsp_tdata  = {2'b00, rsp_thr_ff, rsp_base_ff, rsp_drift_ff,
                        rsp_status_ff, rsp_reading_ff};

endmodule

// ===== hdl/ctbd_const_div.sv =====
module ctbd_const_div #(
   parameter int DIVIDEND_W = 17,
   parameter int DIVISOR    = 10,
   parameter int QUOTIENT_W = 14
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [DIVIDEND_W-1:0] dividend,
   output logic [QUOTIENT_W-1:0] quotient
);

   // exact reciprocal: m = ceil(2^(n+l)/d), l = ceil(log2 d), valid for all n-bit dividends
   localparam int SHIFT  = DIVIDEND_W + $clog2(DIVISOR);
   localparam int MULT_W = DIVIDEND_W + 2;
   localparam int PROD_W = DIVIDEND_W + MULT_W;
   localparam longint unsigned MULT =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [MULT_W-1:0] MULT_C = MULT_W'(MULT);

   logic [PROD_W-1:0]     product;
   logic [PROD_W-1:0]     shifted;
   logic [QUOTIENT_W-1:0] quotient_in;
   logic [QUOTIENT_W-1:0] quotient_ff;

   assign product     = PROD_W'(dividend) * PROD_W'(MULT_C);
   assign shifted     = product >> SHIFT;
   assign quotient_in = QUOTIENT_W'(shifted);

   always_ff @(posedge clock) begin
      if (enable) begin
         quotient_ff <= quotient_in;
      end
   end

   assign quotient = quotient_ff;

endmodule

// ===== hdl/ctbd_checker.sv =====
module ctbd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ctbd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ctbd_pkg::*;

   logic [RD_W-1:0]         reading;
   logic [RSP_STATUS_W-1:0] status;
   logic                    drift;
   logic [RD_W-1:0]         baseline;
   logic [RD_W-1:0]         threshold;

   assign reading   = rsp_tdata[RSP_READING_LSB +: RD_W];
   assign status    = rsp_tdata[RSP_STATUS_LSB +: RSP_STATUS_W];
   assign drift     = rsp_tdata[RSP_DRIFT_BIT];
   assign baseline  = rsp_tdata[RSP_BASE_LSB +: RD_W];
   assign threshold = rsp_tdata[RSP_THR_LSB +: RD_W];

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_thr_below_base: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> threshold <= baseline)
      else $error("threshold above baseline");

   a_touch_below_thr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == STATUS_BEGAN || status == STATUS_TOUCHING)
      |-> reading < threshold)
      else $error("touch reported at or above threshold");

   a_calib_no_drift: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == STATUS_CALIBRATING |-> !drift)
      else $error("drift flagged during calibration");

endmodule

bind cap_touch_baseline_detector ctbd_checker u_ctbd_checker (.*);
